// ===== hw/rtl/sfc1d_pkg.sv =====
package sfc1d_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int COEF_SLOTS    = 8;
    localparam int COEF_WORDS_W  = 2 * CFG_DATA_W;
    localparam int COEF_IDX_W    = 5;

    localparam int STRIDE_REG_W  = 12;
    localparam int TAPS_REG_W    = 4;
    localparam int WIDTH_REG_W   = 12;
    localparam int PAD_REG_W     = 11;
    localparam int PITCH_W       = 13;
    localparam int MAX_ROW_WIDTH = 2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_STRIDE  = 3'd0,
        CFG_TAP_COUNT   = 3'd1,
        CFG_ROW_WIDTH   = 3'd2,
        CFG_ROW_PAD     = 3'd3,
        CFG_INPUT_MODE  = 3'd4,
        CFG_COEFFS_LOW  = 3'd5,
        CFG_COEFFS_HIGH = 3'd6
    } cfg_reg_t;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // control that rides along the cell chain with each sample
    typedef struct packed {
        logic valid;
        logic produce;
        logic row_end;
    } cell_meta_t;

    // coefficient of a tap, zero beyond the eight programmable slots
    function automatic sample_t coef_pick(input logic [COEF_WORDS_W-1:0] words,
                                          input logic [COEF_IDX_W-1:0] idx);
        sample_t c;
        c = '0;
        for (int i = 0; i < COEF_SLOTS; i++) begin
            if (idx == COEF_IDX_W'(i)) begin
                c = words[i*SAMPLE_W +: SAMPLE_W];
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/sfc1d_ram.sv =====
module sfc1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sfc1d_cell.sv =====
module sfc1d_cell #(
    parameter int MAX_STRIDE = 2048,
    parameter bit HAS_DELAY  = 1'b1,
    localparam int SW = $clog2(MAX_STRIDE + 1),
    localparam int AW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [SW-1:0]        stride,
    input  sfc1d_pkg::sample_t   coef,
    input  logic                 tap_on,
    input  sfc1d_pkg::cell_meta_t meta_in,
    input  sfc1d_pkg::sample_t   sample_in,
    input  sfc1d_pkg::sample_t   psum_in,
    output sfc1d_pkg::cell_meta_t meta_out,
    output sfc1d_pkg::sample_t   sample_out,
    output sfc1d_pkg::sample_t   psum_out
);

    sfc1d_pkg::cell_meta_t meta_reg;
    sfc1d_pkg::sample_t    psum_reg;
    sfc1d_pkg::sample_t    psum_next;
    logic [2*sfc1d_pkg::SAMPLE_W-1:0] prod_full;

    // only the low half of the product survives the 16-bit wrap
    assign prod_full = sample_in * coef;
    assign psum_next = psum_in + (tap_on ? prod_full[sfc1d_pkg::SAMPLE_W-1:0]
                                         : sfc1d_pkg::sample_t'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_reg <= '0;
        end else begin
            meta_reg <= meta_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (meta_in.valid) begin
            psum_reg <= psum_next;
        end
    end

    generate
        if (HAS_DELAY) begin : g_delay
            localparam logic [AW-1:0] WP_LAST = AW'(MAX_STRIDE - 1);
            logic [AW-1:0] wp_reg;
            logic [AW-1:0] wp_next;
            logic [SW:0]   rd_sum;
            logic [AW-1:0] raddr;

            // sample that entered this cell one stride of requests ago
            assign rd_sum = ((SW+1)'(wp_reg) >= (SW+1)'(stride))
                          ? (SW+1)'(wp_reg) - (SW+1)'(stride)
                          : (SW+1)'(wp_reg) + (SW+1)'(MAX_STRIDE) - (SW+1)'(stride);
            assign raddr   = rd_sum[AW-1:0];
            assign wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    wp_reg <= '0;
                end else if (meta_in.valid) begin
                    wp_reg <= wp_next;
                end
            end

            sfc1d_ram #(
                .WIDTH (sfc1d_pkg::SAMPLE_W),
                .DEPTH (MAX_STRIDE)
            ) u_ram (
                .aclk  (aclk),
                .we    (meta_in.valid),
                .waddr (wp_reg),
                .wdata (sample_in),
                .re    (meta_in.valid),
                .raddr (raddr),
                .rdata (sample_out)
            );
        end else begin : g_no_delay
            assign sample_out = '0;
        end
    endgenerate

    assign meta_out = meta_reg;
    assign psum_out = psum_reg;

endmodule

// ===== hw/rtl/sfc1d_out_fifo.sv =====
module sfc1d_out_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full,
    output logic [PW:0]      count
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW:0] wr_ptr_reg, wr_ptr_next;
    logic [PW:0] rd_ptr_reg, rd_ptr_next;

    assign wr_ptr_next = wr_ptr_reg + (PW+1)'(wr_en);
    assign rd_ptr_next = rd_ptr_reg + (PW+1)'(rd_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg[PW-1:0]] <= wr_data;
        end
    end

    assign count   = wr_ptr_reg - rd_ptr_reg;
    assign empty   = (count == '0);
    assign full    = (count == (PW+1)'(DEPTH));
    assign rd_data = entry_reg[rd_ptr_reg[PW-1:0]];

endmodule

// ===== hw/rtl/strided_fir_convolution_1d_top.sv =====
// strided 1-d fir over a raster sample stream
//
// s_ channel: one sample per request, s_tuser marks the first sample of a frame.
// m_ channel: one filtered result per active output position, m_tlast on the last
// result of each row; pad columns and the first (taps-1)*stride samples of a frame
// give no result.
// cfg port: cfg_wr_en writes cfg_wdata into the register picked by cfg_index; write
// only while no request is in flight.
// throughput: one sample per clock while the output queue has a free slot.
// a result passes the registers of each cell of the tap chain and is then written
// into the output queue before it shows on m_tvalid.
// the tap chain is MAX_TAPS cells, all but the last with a delay ram read one stride back,
// passing the delayed sample and the running sum to its neighbor for each accepted sample.
// reset: registers return to stride 1, one tap, width 1, no pad, 8-bit mode and
// zero coefficients; position counters clear; delay rams are not cleared, so the
// block takes requests right after reset.
// stall: results wait in a FIFO_DEPTH-entry queue; s_tready drops when every queue
// slot is taken by a stored result or one still in the chain, nothing is lost.
module strided_fir_convolution_1d_top #(
    parameter int MAX_TAPS   = 8,
    parameter int MAX_STRIDE = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tuser,   // [0] frame_start
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] filtered
    output logic        m_tlast,   // row_end
    // register write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int SAMPLE_W   = sfc1d_pkg::SAMPLE_W;
    localparam int TW         = $clog2(MAX_TAPS + 1);
    localparam int SW         = $clog2(MAX_STRIDE + 1);
    localparam int SCW        = (SW > sfc1d_pkg::STRIDE_REG_W) ? SW : sfc1d_pkg::STRIDE_REG_W;
    localparam int MAX_DELAY  = (MAX_TAPS - 1) * MAX_STRIDE;
    localparam int LW         = (MAX_DELAY > 0) ? $clog2(MAX_DELAY + 1) : 1;
    localparam int FIFO_DEPTH = 2 ** $clog2(MAX_TAPS + 3);
    localparam int UW         = $clog2(FIFO_DEPTH + 1);
    localparam int WW         = sfc1d_pkg::WIDTH_REG_W;
    localparam int PTW        = sfc1d_pkg::PITCH_W;

    // configuration registers
    logic [sfc1d_pkg::STRIDE_REG_W-1:0] tap_stride_reg;
    logic [sfc1d_pkg::TAPS_REG_W-1:0]   tap_count_reg;
    logic [WW-1:0]                      row_width_reg;
    logic [sfc1d_pkg::PAD_REG_W-1:0]    row_pad_reg;
    logic                               input_mode_reg;
    logic [sfc1d_pkg::CFG_DATA_W-1:0]   coeffs_low_reg;
    logic [sfc1d_pkg::CFG_DATA_W-1:0]   coeffs_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_stride_reg  <= sfc1d_pkg::STRIDE_REG_W'(1);
            tap_count_reg   <= sfc1d_pkg::TAPS_REG_W'(1);
            row_width_reg   <= WW'(1);
            row_pad_reg     <= '0;
            input_mode_reg  <= 1'b0;
            coeffs_low_reg  <= '0;
            coeffs_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sfc1d_pkg::CFG_TAP_STRIDE:
                    tap_stride_reg <= cfg_wdata[sfc1d_pkg::STRIDE_REG_W-1:0];
                sfc1d_pkg::CFG_TAP_COUNT:
                    tap_count_reg <= cfg_wdata[sfc1d_pkg::TAPS_REG_W-1:0];
                sfc1d_pkg::CFG_ROW_WIDTH:
                    row_width_reg <= cfg_wdata[WW-1:0];
                sfc1d_pkg::CFG_ROW_PAD:
                    row_pad_reg <= cfg_wdata[sfc1d_pkg::PAD_REG_W-1:0];
                sfc1d_pkg::CFG_INPUT_MODE:
                    input_mode_reg <= cfg_wdata[0];
                sfc1d_pkg::CFG_COEFFS_LOW:
                    coeffs_low_reg <= cfg_wdata;
                sfc1d_pkg::CFG_COEFFS_HIGH:
                    coeffs_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // register values clamped into their legal ranges
    logic [SCW-1:0] stride_raw;
    logic [SW-1:0]  stride_eff;
    logic [4:0]     taps_raw;
    logic [TW-1:0]  taps_eff;
    logic [WW-1:0]  width_eff;
    logic [PTW-1:0] pitch;
    logic [LW-1:0]  lag;

    assign stride_raw = SCW'(tap_stride_reg);
    assign stride_eff = (stride_raw == '0) ? SW'(1)
                      : (stride_raw > SCW'(MAX_STRIDE)) ? SW'(MAX_STRIDE)
                      : SW'(stride_raw);
    assign taps_raw   = 5'(tap_count_reg);
    assign taps_eff   = (taps_raw == '0) ? TW'(1)
                      : (taps_raw > 5'(MAX_TAPS)) ? TW'(MAX_TAPS)
                      : TW'(taps_raw);
    assign width_eff  = (row_width_reg == '0) ? WW'(1)
                      : (row_width_reg > WW'(sfc1d_pkg::MAX_ROW_WIDTH))
                        ? WW'(sfc1d_pkg::MAX_ROW_WIDTH)
                      : row_width_reg;
    assign pitch      = PTW'(width_eff) + PTW'(row_pad_reg);
    // samples that must be held before the first result of a frame
    assign lag        = LW'(taps_eff - TW'(1)) * LW'(stride_eff);

    // position tracking, decided when the sample is accepted
    logic [LW-1:0]  sample_count_reg, sample_count_next, sc_cur;
    logic [WW-1:0]  output_column_reg, output_column_next, col_cur;
    logic [PTW-1:0] col_inc;
    logic           accept;
    logic           past_lag;
    logic           produce;
    logic           row_end;

    assign accept   = s_tvalid && s_tready;
    // frame start clears both counters before this sample is looked at
    assign sc_cur   = s_tuser ? '0 : sample_count_reg;
    assign col_cur  = s_tuser ? '0 : output_column_reg;
    assign col_inc  = PTW'(col_cur) + PTW'(1);
    assign past_lag = (sc_cur >= lag);
    assign produce  = past_lag && (col_cur < width_eff);
    assign row_end  = (col_cur == width_eff - WW'(1));

    always_comb begin
        output_column_next = col_cur;
        if (past_lag) begin
            output_column_next = (col_inc >= pitch) ? '0 : col_inc[WW-1:0];
        end
        sample_count_next = (sc_cur < LW'(MAX_DELAY)) ? sc_cur + LW'(1) : sc_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg  <= '0;
            output_column_reg <= '0;
        end else if (accept) begin
            sample_count_reg  <= sample_count_next;
            output_column_reg <= output_column_next;
        end
    end

    // tap chain: cell j sees the sample j strides old and adds its tap
    sfc1d_pkg::cell_meta_t chain_meta   [MAX_TAPS+1];
    sfc1d_pkg::sample_t    chain_sample [MAX_TAPS+1];
    sfc1d_pkg::sample_t    chain_psum   [MAX_TAPS+1];
    logic [sfc1d_pkg::COEF_WORDS_W-1:0] coef_words;

    assign coef_words = {coeffs_high_reg, coeffs_low_reg};

    // 8-bit mode keeps the low byte, zero extended
    assign chain_sample[0]     = input_mode_reg ? s_tdata : {8'd0, s_tdata[7:0]};
    assign chain_psum[0]       = '0;
    assign chain_meta[0].valid   = accept;
    assign chain_meta[0].produce = produce;
    assign chain_meta[0].row_end = row_end;

    generate
        for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
            logic               tap_on;
            sfc1d_pkg::sample_t coef;

            // oldest sample takes tap 0, so cell j uses tap taps-1-j
            assign tap_on = (TW'(j) < taps_eff);
            assign coef   = sfc1d_pkg::coef_pick(coef_words,
                                sfc1d_pkg::COEF_IDX_W'(taps_eff - TW'(1) - TW'(j)));

            sfc1d_cell #(
                .MAX_STRIDE (MAX_STRIDE),
                .HAS_DELAY  (j < MAX_TAPS - 1)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .stride     (stride_eff),
                .coef       (coef),
                .tap_on     (tap_on),
                .meta_in    (chain_meta[j]),
                .sample_in  (chain_sample[j]),
                .psum_in    (chain_psum[j]),
                .meta_out   (chain_meta[j+1]),
                .sample_out (chain_sample[j+1]),
                .psum_out   (chain_psum[j+1])
            );
        end
    endgenerate

    // output queue with slots reserved at accept time
    logic                        fifo_wr;
    logic                        fifo_rd;
    logic [SAMPLE_W:0]           fifo_rd_data;
    logic                        fifo_empty;
    logic                        fifo_full;
    logic [$clog2(FIFO_DEPTH):0] fifo_count;
    logic [UW-1:0]               used_reg, used_next;

    assign fifo_wr = chain_meta[MAX_TAPS].valid && chain_meta[MAX_TAPS].produce;
    assign fifo_rd = m_tvalid && m_tready;

    sfc1d_out_fifo #(
        .WIDTH (SAMPLE_W + 1),
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (fifo_wr),
        .wr_data ({chain_meta[MAX_TAPS].row_end, chain_psum[MAX_TAPS]}),
        .rd_en   (fifo_rd),
        .rd_data (fifo_rd_data),
        .empty   (fifo_empty),
        .full    (fifo_full),
        .count   (fifo_count)
    );

    // results stored plus results still travelling down the chain
    assign used_next = used_reg + UW'(accept && produce) - UW'(fifo_rd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    assign s_tready = (used_reg < UW'(FIFO_DEPTH));
    assign m_tvalid = !fifo_empty;
    assign m_tdata  = fifo_rd_data[SAMPLE_W-1:0];
    assign m_tlast  = fifo_rd_data[SAMPLE_W];

    // every result leaving the chain has a free queue entry
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_wr |-> !fifo_full)
        else $error("output queue written while full");

    // each stored result is still counted as reserved
    a_reserve_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        (UW+1)'(fifo_count) <= (UW+1)'(used_reg))
        else $error("queue holds more results than reserved slots");

    a_reserve_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(FIFO_DEPTH))
        else $error("reserved slots exceed queue depth");

    // a result-bearing sample reaches the chain end through the meta register of every cell, with no stall between
    a_chain_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && produce) |-> ##MAX_TAPS
            (chain_meta[MAX_TAPS].valid && chain_meta[MAX_TAPS].produce))
        else $error("result lost in tap chain");

endmodule

// ===== bench/tb_strided_fir_convolution_1d_top.sv =====
`timescale 1ns / 1ps

module tb_strided_fir_convolution_1d_top;
    import sfc1d_pkg::*;

    localparam int MAX_TAPS      = 8;
    localparam int MAX_STRIDE    = 2048;
    localparam int MAX_DELAY     = (MAX_TAPS - 1) * MAX_STRIDE;
    localparam int HIST_DEPTH    = MAX_DELAY + 1;
    // time for the tap cells and the output queue to empty, with margin
    localparam int SETTLE_CYCLES = 2 * (MAX_TAPS + 1) + 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT      = 13;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [15:0] sample;
        logic        frame_start;
    } sample_req_t;

    typedef struct {
        logic [15:0] filtered;
        logic        row_end;
    } filt_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [15:0] sample
    logic        s_tuser = 1'b0;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] filtered
    logic        m_tlast;          // row_end
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = CFG_TAP_STRIDE;
    logic [63:0] cfg_wdata = '0;

    strided_fir_convolution_1d_top #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_STRIDE (MAX_STRIDE)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // stimulus and scoreboard state
    sample_req_t  sample_queue[$];
    filt_result_t expected_filtered[$];
    sample_req_t  next_req;
    filt_result_t want;
    int           queued_reqs = 0;
    int           accepted_reqs = 0;
    int           mismatches = 0;
    int           idle_cycles = 0;
    logic         req_taken = 1'b0;
    logic         quiet = 1'b0;       // no random idling on either side
    logic         hold_arm = 1'b0;    // asks the receiver for one long hold-off
    logic         hold_used = 1'b0;
    int           hold_left = 0;

    // predictor copy of the registers and the stream state
    logic [11:0]  stride_reg = 12'd1;
    logic [3:0]   taps_reg = 4'd1;
    logic [11:0]  width_reg = 12'd1;
    logic [10:0]  pad_reg = '0;
    logic         mode_reg = 1'b0;
    logic [63:0]  coef_lo = '0;
    logic [63:0]  coef_hi = '0;
    logic [15:0]  sample_hist [0:HIST_DEPTH-1];
    int           hist_ptr = 0;
    int           seen_count = 0;
    int           column = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // expected result, if any, of one accepted sample
    task automatic predict_filtered(input logic [15:0] raw, input logic fs);
        int           stride;
        int           taps;
        int           width;
        int           pitch;
        int           lag;
        int           age;
        int           k;
        logic [15:0]  cur;
        logic [15:0]  acc;
        logic [15:0]  x;
        logic [15:0]  c;
        filt_result_t r;
        stride = (stride_reg == 0) ? 1 :
                 (stride_reg > MAX_STRIDE) ? MAX_STRIDE : int'(stride_reg);
        taps   = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
        width  = (width_reg == 0) ? 1 :
                 (width_reg > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(width_reg);
        pitch  = width + int'(pad_reg);
        lag    = (taps - 1) * stride;
        cur    = mode_reg ? raw : {8'h00, raw[7:0]};
        if (fs) begin
            seen_count = 0;
            column = 0;
        end
        if (seen_count >= lag) begin
            if (column < width) begin
                acc = '0;
                for (k = 0; k < taps; k++) begin
                    age = (taps - 1 - k) * stride;
                    if (age == 0) begin
                        x = cur;
                    end else begin
                        x = sample_hist[(hist_ptr + HIST_DEPTH - age % HIST_DEPTH) % HIST_DEPTH];
                    end
                    c = (k < 4) ? coef_lo[16*k +: 16] : coef_hi[16*(k-4) +: 16];
                    acc = acc + x * c;   // 16-bit context wraps products and sums
                end
                r.filtered = acc;
                r.row_end  = (column == width - 1);
                expected_filtered.push_back(r);
            end
            column = (column + 1 >= pitch) ? 0 : column + 1;
        end
        sample_hist[hist_ptr] = cur;
        hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        if (seen_count < MAX_DELAY) seen_count++;
    endtask

    // request driver: holds a request until it is taken, then maybe idles
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (sample_queue.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                next_req = sample_queue.pop_front();
                s_tdata  <= next_req.sample;
                s_tuser  <= next_req.frame_start;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls and one long hold-off on request
    always @(negedge aclk) begin
        if (hold_arm && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: results are checked before the same edge's request is predicted
    always @(posedge aclk) begin
        req_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_filtered.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("unexpected result: filtered %h row_end %b", m_tdata, m_tlast);
                    end
                end else begin
                    want = expected_filtered.pop_front();
                    if (m_tdata !== want.filtered || m_tlast !== want.row_end) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("mismatch: filtered exp %h got %h, row_end exp %b got %b",
                                     want.filtered, m_tdata, want.row_end, m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_filtered(s_tdata, s_tuser);
                accepted_reqs++;
            end
        end
    end

    // cycles with neither a request nor a result taken
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("tb_strided_fir_convolution_1d_top: errors");
        $finish;
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        case (idx)
            CFG_TAP_STRIDE:  stride_reg = value[11:0];
            CFG_TAP_COUNT:   taps_reg   = value[3:0];
            CFG_ROW_WIDTH:   width_reg  = value[11:0];
            CFG_ROW_PAD:     pad_reg    = value[10:0];
            CFG_INPUT_MODE:  mode_reg   = value[0];
            CFG_COEFFS_LOW:  coef_lo    = value;
            CFG_COEFFS_HIGH: coef_hi    = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic program_all(input int stride, input int taps, input int width,
                               input int pad, input int mode,
                               input logic [63:0] lo, input logic [63:0] hi);
        write_reg(CFG_TAP_STRIDE, 64'(stride));
        write_reg(CFG_TAP_COUNT, 64'(taps));
        write_reg(CFG_ROW_WIDTH, 64'(width));
        write_reg(CFG_ROW_PAD, 64'(pad));
        write_reg(CFG_INPUT_MODE, 64'(mode));
        write_reg(CFG_COEFFS_LOW, lo);
        write_reg(CFG_COEFFS_HIGH, hi);
    endtask

    task automatic push_sample(input logic [15:0] sample, input logic fs);
        sample_req_t r;
        r.sample = sample;
        r.frame_start = fs;
        sample_queue.push_back(r);
        queued_reqs++;
    endtask

    // random samples, the first optionally opening a frame
    task automatic queue_samples(input int n, input int frame_pct, input logic open_frame);
        int i;
        @(posedge aclk);
        for (i = 0; i < n; i++) begin
            push_sample(16'($urandom),
                        (i == 0) ? open_frame : ($urandom_range(99) < frame_pct));
        end
    endtask

    // wait out every request and result, then let the tap chain empty
    task automatic drain_all();
        while (accepted_reqs != queued_reqs || expected_filtered.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: one zero-weight tap, every sample ends a row
        @(posedge aclk);
        push_sample(16'h00ff, 1'b0);
        push_sample(16'hff00, 1'b1);
        push_sample(16'h1234, 1'b0);
        drain_all();

        // three taps with extreme weights, signed 16-bit samples at their limits,
        // pad columns and a frame restart in mid-stream
        program_all(1, 3, 4, 2, 1, 64'h0001_ffff_8000_7fff, 64'h0);
        @(posedge aclk);
        push_sample(16'h7fff, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'hffff, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'hffff, 1'b0);
        push_sample(16'h1234, 1'b1);
        push_sample(16'h8001, 1'b0);
        push_sample(16'hfffe, 1'b0);
        push_sample(16'h7ffe, 1'b0);
        push_sample(16'h0000, 1'b0);
        drain_all();

        // zero stride, zero taps and zero width act as one; 8-bit mode drops the high byte
        program_all(0, 0, 0, 5, 0, 64'h0000_0000_0000_8000, '1);
        @(posedge aclk);
        push_sample(16'hffff, 1'b1);
        push_sample(16'h0080, 1'b0);
        push_sample(16'h7f00, 1'b0);
        push_sample(16'h80ff, 1'b0);
        push_sample(16'h0001, 1'b0);
        drain_all();

        // horizontal filter; the receiver holds off so the input backs up
        program_all(1, 5, 12, 3, 1, {$urandom, $urandom}, {$urandom, $urandom});
        @(posedge aclk);
        hold_arm = 1'b1;
        queue_samples(120, 2, 1'b1);
        drain_all();

        // mode change mid-stream: stored samples keep their 16-bit form
        write_reg(CFG_INPUT_MODE, 64'(0));
        queue_samples(40, 0, 1'b0);
        // sender pauses until every result is out, then the stream goes on
        drain_all();
        queue_samples(30, 0, 1'b0);
        drain_all();

        // narrower row mid-stream: column counter past the pitch wraps to zero
        write_reg(CFG_ROW_WIDTH, 64'(3));
        queue_samples(40, 0, 1'b0);
        drain_all();

        // vertical filter over the row pitch, no idling on either side
        @(posedge aclk);
        quiet = 1'b1;
        program_all(8, 4, 6, 2, 1, {$urandom, $urandom}, {$urandom, $urandom});
        queue_samples(100, 2, 1'b1);
        drain_all();
        @(posedge aclk);
        quiet = 1'b0;

        // tap count above the maximum acts as eight
        program_all(2, 15, 7, 0, 0, {$urandom, $urandom}, {$urandom, $urandom});
        queue_samples(80, 3, 1'b1);
        drain_all();

        program_all(3, 6, 9, 1, 1, {$urandom, $urandom}, {$urandom, $urandom});
        queue_samples(100, 3, 1'b1);
        drain_all();

        // deepest delay line: eight taps at the largest stride, widest row and pad
        program_all(2048, 8, 2048, 2047, 1, {$urandom, $urandom}, {$urandom, $urandom});
        queue_samples(MAX_DELAY + 60, 0, 1'b1);
        drain_all();

        // stride and width above their maximum act as the maximum
        program_all(4095, 2, 4095, 0, 0, {$urandom, $urandom}, {$urandom, $urandom});
        queue_samples(MAX_STRIDE + 60, 0, 1'b1);
        drain_all();

        if (mismatches == 0 && expected_filtered.size() == 0) begin
            $display("tb_strided_fir_convolution_1d_top: clean");
        end else begin
            $display("tb_strided_fir_convolution_1d_top: errors");
        end
        $finish;
    end

endmodule
